/* rtl/deque_remove_unique_unit_defines.svh */
// assertion macros shared by the deque unit
`ifndef DEQUE_REMOVE_UNIQUE_UNIT_DEFINES_SVH
`define DEQUE_REMOVE_UNIQUE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DQRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque unit check failed");

// next-cycle implication, checked out of reset
`define DQRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque unit check failed");

`endif

/* rtl/dqru_pkg.sv */
package dqru_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNIQUE     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FRONT,
        ST_BACK,
        ST_FIN
    } t_state;

endpackage

/* rtl/dqru_ram.sv */
module dqru_ram #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [dqru_pkg::DATA_W-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [dqru_pkg::DATA_W-1:0]       o_rdata
);

    logic [dqru_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [dqru_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/deque_remove_unique_unit.sv */
// Double-ended queue of signed 32-bit words kept as a ring in a DEPTH-entry
// single-port-write, registered-read RAM. Every accepted word gives exactly
// one result word (status, count, front, back, removed). Push and pop pass
// from accept through the FRONT, BACK and FIN states to the result;
// remove-value and unique first make one compaction pass that streams every
// live entry through the RAM read port, one entry per cycle, comparing it
// against the search value or the last kept entry and writing kept entries
// back to their new place. The FRONT and BACK states address the front and
// back entries for reading from the RAM. The input is not ready while an
// operation runs; a finished result sits in an output register, so a new
// word can be taken while it waits. Counts and the removed figure are reported modulo 32.
`include "deque_remove_unique_unit_defines.svh"

module deque_remove_unique_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dqru_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [dqru_pkg::DATA_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dqru_pkg::STATUS_W-1:0]       o_status,
    output logic [dqru_pkg::COUNT_W-1:0]        o_count,
    output logic signed [dqru_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [dqru_pkg::DATA_W-1:0]  o_back_value,
    output logic [dqru_pkg::COUNT_W-1:0]        o_removed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [AW-1:0] offs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

    dqru_pkg::t_state r_state, n_state;

    logic [AW-1:0]                       r_first;
    logic [CW-1:0]                       r_cnt;
    logic                                r_out_valid;

    logic [dqru_pkg::MODE_W-1:0]         r_mode;
    logic signed [dqru_pkg::DATA_W-1:0]  r_val;
    logic [dqru_pkg::STATUS_W-1:0]       r_status;
    logic [CW-1:0]                       r_removed;
    logic [CW-1:0]                       r_rd_idx;
    logic [CW-1:0]                       r_kept;
    logic                                r_pend;
    logic                                r_found;
    logic signed [dqru_pkg::DATA_W-1:0]  r_last;
    logic signed [dqru_pkg::DATA_W-1:0]  r_front;

    logic [dqru_pkg::STATUS_W-1:0]       r_o_status;
    logic [dqru_pkg::COUNT_W-1:0]        r_o_count;
    logic signed [dqru_pkg::DATA_W-1:0]  r_o_front;
    logic signed [dqru_pkg::DATA_W-1:0]  r_o_back;
    logic [dqru_pkg::COUNT_W-1:0]        r_o_removed;

    logic                                in_fire;
    logic                                out_space;
    logic                                is_full;
    logic                                is_empty;
    logic                                rd_more;
    logic                                skip;
    logic                                walk_done;
    logic [CW-1:0]                       cnt_m1;
    logic [AW-1:0]                       first_dec;
    logic [AW-1:0]                       first_inc;
    logic [AW-1:0]                       back_slot;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [dqru_pkg::DATA_W-1:0]         ram_wdata;
    logic [AW-1:0]                       ram_raddr;
    logic [dqru_pkg::DATA_W-1:0]         ram_rdata;

    dqru_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == dqru_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_space  = !r_out_valid || i_out_ready;
    assign is_full    = (r_cnt == DEPTH_CNT);
    assign is_empty   = (r_cnt == '0);
    assign cnt_m1     = r_cnt - CW'(1);
    assign first_dec  = (r_first == '0) ? LAST_SLOT : r_first - AW'(1);
    assign first_inc  = (r_first == LAST_SLOT) ? '0 : r_first + AW'(1);
    assign back_slot  = f_slot(r_first, cnt_m1[AW-1:0]);
    assign rd_more    = (r_rd_idx != r_cnt);
    assign walk_done  = !rd_more && !r_pend;

    // remove drops the first match only; unique drops repeats of the last kept word
    always_comb begin
        if (r_mode == dqru_pkg::MODE_REMOVE) begin
            skip = !r_found && (ram_rdata == r_val);
        end else begin
            skip = (r_kept != '0) && (ram_rdata == r_last);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqru_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_mode == dqru_pkg::MODE_REMOVE || i_mode == dqru_pkg::MODE_UNIQUE) begin
                        n_state = dqru_pkg::ST_WALK;
                    end else begin
                        n_state = dqru_pkg::ST_FRONT;
                    end
                end
            end
            dqru_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = dqru_pkg::ST_FRONT;
                end
            end
            dqru_pkg::ST_FRONT: n_state = dqru_pkg::ST_BACK;
            dqru_pkg::ST_BACK:  n_state = dqru_pkg::ST_FIN;
            dqru_pkg::ST_FIN: begin
                if (out_space) begin
                    n_state = dqru_pkg::ST_IDLE;
                end
            end
            default: n_state = dqru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_slot(r_first, r_cnt[AW-1:0]);
        ram_wdata = i_value;
        ram_raddr = back_slot;
        unique case (r_state)
            dqru_pkg::ST_IDLE: begin
                if (i_mode == dqru_pkg::MODE_PUSH_FRONT) begin
                    ram_waddr = first_dec;
                end
                ram_we = in_fire && !is_full &&
                         (i_mode == dqru_pkg::MODE_PUSH_FRONT ||
                          i_mode == dqru_pkg::MODE_PUSH_BACK);
            end
            dqru_pkg::ST_WALK: begin
                ram_raddr = f_slot(r_first, r_rd_idx[AW-1:0]);
                ram_we    = r_pend && !skip;
                ram_waddr = f_slot(r_first, r_kept[AW-1:0]);
                ram_wdata = ram_rdata;
            end
            dqru_pkg::ST_FRONT: ram_raddr = r_first;
            dqru_pkg::ST_BACK:  ram_raddr = back_slot;
            dqru_pkg::ST_FIN:   ram_raddr = back_slot;
            default: ram_raddr = back_slot;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dqru_pkg::ST_IDLE;
            r_first     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                unique case (i_mode)
                    dqru_pkg::MODE_PUSH_FRONT: begin
                        if (!is_full) begin
                            r_first <= first_dec;
                            r_cnt   <= r_cnt + CW'(1);
                        end
                    end
                    dqru_pkg::MODE_PUSH_BACK: begin
                        if (!is_full) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end
                    dqru_pkg::MODE_POP_FRONT: begin
                        if (!is_empty) begin
                            r_first <= first_inc;
                            r_cnt   <= cnt_m1;
                        end
                    end
                    dqru_pkg::MODE_POP_BACK: begin
                        if (!is_empty) begin
                            r_cnt <= cnt_m1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == dqru_pkg::ST_WALK && walk_done) begin
                r_cnt <= r_kept;
            end
            if (r_state == dqru_pkg::ST_FIN && out_space) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operation payload and the compaction pass
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode    <= i_mode;
            r_val     <= i_value;
            r_rd_idx  <= '0;
            r_kept    <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            unique case (i_mode) inside
                dqru_pkg::MODE_PUSH_FRONT, dqru_pkg::MODE_PUSH_BACK: begin
                    r_status  <= is_full ? dqru_pkg::STAT_FULL : dqru_pkg::STAT_DONE;
                    r_removed <= CW'(0);
                end
                dqru_pkg::MODE_POP_FRONT, dqru_pkg::MODE_POP_BACK: begin
                    r_status  <= is_empty ? dqru_pkg::STAT_EMPTY : dqru_pkg::STAT_DONE;
                    r_removed <= is_empty ? CW'(0) : CW'(1);
                end
                default: begin
                    r_status  <= dqru_pkg::STAT_DONE;
                    r_removed <= CW'(0);
                end
            endcase
        end
        if (r_state == dqru_pkg::ST_WALK) begin
            r_pend <= rd_more;
            if (rd_more) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (r_pend) begin
                if (skip) begin
                    r_found <= 1'b1;
                end else begin
                    r_kept <= r_kept + CW'(1);
                    r_last <= ram_rdata;
                end
            end
            if (walk_done) begin
                r_removed <= r_cnt - r_kept;
                if (r_mode == dqru_pkg::MODE_REMOVE && !r_found) begin
                    r_status <= dqru_pkg::STAT_NOT_FOUND;
                end
            end
        end
        if (r_state == dqru_pkg::ST_BACK) begin
            r_front <= ram_rdata;
        end
        if (r_state == dqru_pkg::ST_FIN && out_space) begin
            r_o_status  <= r_status;
            r_o_count   <= dqru_pkg::COUNT_W'(r_cnt);
            r_o_removed <= dqru_pkg::COUNT_W'(r_removed);
            r_o_front   <= is_empty ? '0 : r_front;
            r_o_back    <= is_empty ? '0 : ram_rdata;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_count       = r_o_count;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_removed     = r_o_removed;

    `DQRU_ASSERT_IMPL(a_cnt_bounded, i_clk, i_rst_n, 1'b1, r_cnt <= DEPTH_CNT)
    `DQRU_ASSERT_IMPL(a_write_behind_read, i_clk, i_rst_n, r_state == dqru_pkg::ST_WALK, r_kept <= r_rd_idx)
    `DQRU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_in_ready)
    `DQRU_ASSERT_IMPL(a_removed_means_done, i_clk, i_rst_n, o_out_valid && o_removed != '0, o_status == dqru_pkg::STAT_DONE)

endmodule
